// ===== hw/rtl/epz_pkg.sv =====
// Shared types, constants and tables for the equirectangular point z-buffer.
// No dependencies.
package epz_pkg;

    localparam int MAP_WIDTH        = 1024;
    localparam int MAP_HEIGHT       = 512;
    localparam int POINT_INDEX_BITS = 40;

    localparam int COL_BITS  = $clog2(MAP_WIDTH);
    localparam int ROW_BITS  = $clog2(MAP_HEIGHT);
    localparam int CELL_BITS = COL_BITS + ROW_BITS;
    localparam longint MAP_CELLS = longint'(MAP_WIDTH) * longint'(MAP_HEIGHT);

    localparam int ROT_W     = 54;
    localparam int COEF_W    = 18;
    localparam int COORD_W   = 32;
    localparam int RANGE_W   = 31;
    localparam int ADDR_W    = 19;
    localparam int OUT_COL_W = 10;
    localparam int OUT_ROW_W = 9;
    localparam int OWNER_W   = 40;
    localparam int CFG_IDX_W = 3;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS    = $clog2(CORDIC_STEPS);
    localparam int ANGLE_W      = 34;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 31'd13107;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 31'd4259840;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT0, CFG_ROT1, CFG_ROT2, CFG_ORG_X, CFG_ORG_Y, CFG_ORG_Z,
        CFG_MIN_RANGE, CFG_MAX_RANGE
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0][ROT_W-1:0]      rot;
        logic signed [COORD_W-1:0]  org_x;
        logic signed [COORD_W-1:0]  org_y;
        logic signed [COORD_W-1:0]  org_z;
        logic [RANGE_W-1:0]         min_range;
        logic [RANGE_W-1:0]         max_range;
    } t_cfg;

    typedef struct packed {
        logic                       action;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic                       point_finite;
        logic [ADDR_W-1:0]          pixel_address;
    } t_in_item;

    typedef struct packed {
        logic                   accepted;
        logic                   updated;
        logic [OUT_COL_W-1:0]   pixel_column;
        logic [OUT_ROW_W-1:0]   pixel_row;
        logic [RANGE_W-1:0]     depth;
        logic [OWNER_W-1:0]     owner_index;
        logic                   owner_valid;
    } t_out_item;

    typedef enum logic [1:0] {JOB_READ, JOB_REJECT, JOB_POINT} t_job_kind;

    typedef struct packed {
        t_job_kind                      kind;
        logic                           in_map;
        logic [COL_BITS-1:0]            col;
        logic [ROW_BITS-1:0]            row;
        logic [RANGE_W-1:0]             distance;
        logic [POINT_INDEX_BITS-1:0]    ordinal;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // atan(2^-i) in turns, Q0.32
    function automatic logic [31:0] arc_angle(input logic [STEP_BITS-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/epz_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
// Depends on epz_pkg.
interface epz_in_if;
    logic               valid;
    logic               ready;
    epz_pkg::t_in_item  data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

interface epz_out_if;
    logic               valid;
    logic               ready;
    epz_pkg::t_out_item data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/epz_isqrt.sv =====
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Depends on nothing.
module epz_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] w_shift, w_trial, w_diff;
    logic        w_ge;

    assign w_shift = {r_rem, r_rad[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_shift >= w_trial;
    assign w_diff  = w_shift - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= w_ge ? w_diff[33:0] : w_shift[33:0];
                r_root <= {r_root[30:0], w_ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== hw/rtl/epz_cordic.sv =====
// Vectoring CORDIC giving atan2(y, x) in turns, one micro-rotation per cycle.
// Depends on epz_pkg.
module epz_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [32:0]                  i_y,
    input  logic signed [32:0]                  i_x,
    output logic                                o_done,
    output logic signed [epz_pkg::ANGLE_W-1:0]  o_angle
);
    logic                                   r_busy, r_done, r_zero;
    logic [epz_pkg::STEP_BITS-1:0]          r_i;
    logic signed [51:0]                     r_x, r_y;
    logic signed [epz_pkg::ANGLE_W-1:0]     r_ang;
    logic signed [51:0]                     w_x0, w_y0, w_dx, w_dy;
    logic signed [epz_pkg::ANGLE_W-1:0]     w_arc;

    assign w_x0  = 52'(i_x) <<< 16;
    assign w_y0  = 52'(i_y) <<< 16;
    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_arc = $signed({2'b00, epz_pkg::arc_angle(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_zero <= (i_x == '0) && (i_y == '0);
                r_i    <= '0;
                r_busy <= 1'b1;
                if (w_x0 < 0) begin
                    if (w_y0 >= 0) begin
                        r_x   <= w_y0;
                        r_y   <= -w_x0;
                        r_ang <= epz_pkg::QUARTER_TURN;
                    end else begin
                        r_x   <= -w_y0;
                        r_y   <= w_x0;
                        r_ang <= -epz_pkg::QUARTER_TURN;
                    end
                end else begin
                    r_x   <= w_x0;
                    r_y   <= w_y0;
                    r_ang <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x   <= r_x + w_dx;
                    r_y   <= r_y - w_dy;
                    r_ang <= r_ang + w_arc;
                end else begin
                    r_x   <= r_x - w_dx;
                    r_y   <= r_y + w_dy;
                    r_ang <= r_ang - w_arc;
                end
                r_i <= r_i + 1'b1;
                if (r_i == epz_pkg::STEP_BITS'(epz_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : r_ang;
endmodule

// ===== hw/rtl/epz_front.sv =====
// Front end: accepts transactions, transforms and range-checks points, finds
// the pixel, and pushes one job per transaction. Depends on epz_pkg, epz_if,
// epz_isqrt and epz_cordic.
module epz_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  epz_pkg::t_cfg   i_cfg,
    input  logic            i_hold,
    epz_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output epz_pkg::t_job   o_job
);
    typedef enum logic [3:0] {
        F_IDLE, F_MUL, F_ACC, F_SQM, F_SQA, F_DGO, F_DWAIT, F_RGO, F_RWAIT,
        F_LONGO, F_LONWAIT, F_LATGO, F_LATWAIT, F_MAP, F_PUSH
    } t_state;

    t_state                                     r_state;
    logic [epz_pkg::POINT_INDEX_BITS-1:0]       r_count;
    epz_pkg::t_job                              r_job;
    logic signed [32:0]                         r_off [3];
    logic signed [31:0]                         r_loc [3];
    logic [1:0]                                 r_r, r_k;
    logic signed [50:0]                         r_prod;
    logic signed [53:0]                         r_acc;
    logic [61:0]                                r_sq;
    logic [63:0]                                r_rad, r_rad_xy;
    logic [31:0]                                r_dist, r_rho;
    logic signed [epz_pkg::ANGLE_W-1:0]         r_lon, r_lat;

    logic [epz_pkg::ROT_W-1:0]                  w_row;
    logic signed [epz_pkg::COEF_W-1:0]          w_coef;
    logic signed [32:0]                         w_offk;
    logic signed [50:0]                         w_prod;
    logic signed [53:0]                         w_sum, w_locw;
    logic                                       w_loc_bad;
    logic signed [31:0]                         w_sqk, w_abs;
    logic [61:0]                                w_sqp;
    logic [63:0]                                w_rad_next;
    logic                                       w_range_bad;
    logic                                       w_sq_start, w_sq_done;
    logic [63:0]                                w_radicand;
    logic [31:0]                                w_root;
    logic                                       w_cd_start, w_cd_done;
    logic signed [32:0]                         w_cd_y, w_cd_x;
    logic signed [epz_pkg::ANGLE_W-1:0]         w_angle;
    logic signed [34:0]                         w_lon_v;
    logic signed [35:0]                         w_lat_v, w_row_v;
    logic [epz_pkg::ROW_BITS-1:0]               w_row_px;

    always_comb begin
        unique case (r_r)
            2'd0:    w_row = i_cfg.rot[0];
            2'd1:    w_row = i_cfg.rot[1];
            default: w_row = i_cfg.rot[2];
        endcase
        unique case (r_k)
            2'd0: begin
                w_coef = $signed(w_row[17:0]);
                w_offk = r_off[0];
                w_sqk  = r_loc[0];
            end
            2'd1: begin
                w_coef = $signed(w_row[35:18]);
                w_offk = r_off[1];
                w_sqk  = r_loc[1];
            end
            default: begin
                w_coef = $signed(w_row[53:36]);
                w_offk = r_off[2];
                w_sqk  = r_loc[2];
            end
        endcase
    end

    assign w_prod      = 51'(w_coef) * 51'(w_offk);
    assign w_sum       = r_acc + 54'(r_prod);
    assign w_locw      = (w_sum + 54'sd32768) >>> 16;
    assign w_loc_bad   = (w_locw > 54'sd2147483647) || (w_locw < -54'sd2147483647);
    assign w_abs       = (w_sqk < 0) ? -w_sqk : w_sqk;
    assign w_sqp       = 62'(w_abs[30:0]) * 62'(w_abs[30:0]);
    assign w_rad_next  = r_rad + 64'(r_sq);
    assign w_range_bad = (r_dist < {1'b0, i_cfg.min_range}) ||
                         (r_dist > {1'b0, i_cfg.max_range});

    assign w_sq_start = (r_state == F_DGO) || ((r_state == F_RGO) && !w_range_bad);
    assign w_radicand = (r_state == F_DGO) ? r_rad : r_rad_xy;
    assign w_cd_start = (r_state == F_LONGO) || (r_state == F_LATGO);
    assign w_cd_y     = (r_state == F_LONGO) ? -33'(r_loc[1]) : 33'(r_loc[2]);
    assign w_cd_x     = (r_state == F_LONGO) ? 33'(r_loc[0]) : $signed({1'b0, r_rho});

    epz_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_radicand),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    epz_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cd_start),
        .i_y     (w_cd_y),
        .i_x     (w_cd_x),
        .o_done  (w_cd_done),
        .o_angle (w_angle)
    );

    assign w_lon_v = 35'(r_lon) + 35'sd2147483648;
    assign w_lat_v = 36'sd2147483648 - (36'(r_lat) <<< 1);
    assign w_row_v = w_lat_v >>> (32 - epz_pkg::ROW_BITS);

    always_comb begin
        if (w_row_v < 0) begin
            w_row_px = '0;
        end else if (w_row_v > 36'(epz_pkg::MAP_HEIGHT - 1)) begin
            w_row_px = epz_pkg::ROW_BITS'(epz_pkg::MAP_HEIGHT - 1);
        end else begin
            w_row_px = w_row_v[epz_pkg::ROW_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_job.distance <= '0;
                        r_job.ordinal  <= r_count;
                        if (i_in.data.action) begin
                            r_job.kind   <= epz_pkg::JOB_READ;
                            r_job.in_map <= 64'(i_in.data.pixel_address) < epz_pkg::MAP_CELLS;
                            r_job.col    <= i_in.data.pixel_address[epz_pkg::COL_BITS-1:0];
                            r_job.row    <= epz_pkg::ROW_BITS'(
                                i_in.data.pixel_address >> epz_pkg::COL_BITS);
                            r_state      <= F_PUSH;
                        end else begin
                            r_count      <= r_count + 1'b1;
                            r_job.kind   <= epz_pkg::JOB_REJECT;
                            r_job.in_map <= 1'b0;
                            r_job.col    <= '0;
                            r_job.row    <= '0;
                            r_off[0] <= 33'(i_in.data.point_x) - 33'(i_cfg.org_x);
                            r_off[1] <= 33'(i_in.data.point_y) - 33'(i_cfg.org_y);
                            r_off[2] <= 33'(i_in.data.point_z) - 33'(i_cfg.org_z);
                            r_r   <= '0;
                            r_k   <= '0;
                            r_acc <= '0;
                            r_state <= i_in.data.point_finite ? F_MUL : F_PUSH;
                        end
                    end
                end
                F_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    if (r_k == 2'd2) begin
                        if (w_loc_bad) begin
                            r_state <= F_PUSH;
                        end else begin
                            r_loc[r_r] <= w_locw[31:0];
                            r_acc      <= '0;
                            r_k        <= '0;
                            if (r_r == 2'd2) begin
                                r_rad   <= '0;
                                r_state <= F_SQM;
                            end else begin
                                r_r     <= r_r + 2'd1;
                                r_state <= F_MUL;
                            end
                        end
                    end else begin
                        r_acc   <= w_sum;
                        r_k     <= r_k + 2'd1;
                        r_state <= F_MUL;
                    end
                end
                F_SQM: begin
                    r_sq    <= w_sqp;
                    r_state <= F_SQA;
                end
                F_SQA: begin
                    r_rad <= w_rad_next;
                    if (r_k == 2'd1) begin
                        r_rad_xy <= w_rad_next;
                    end
                    if (r_k == 2'd2) begin
                        r_state <= F_DGO;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= F_SQM;
                    end
                end
                F_DGO: r_state <= F_DWAIT;
                F_DWAIT: begin
                    if (w_sq_done) begin
                        r_dist  <= w_root;
                        r_state <= F_RGO;
                    end
                end
                F_RGO: r_state <= w_range_bad ? F_PUSH : F_RWAIT;
                F_RWAIT: begin
                    if (w_sq_done) begin
                        r_rho   <= w_root;
                        r_state <= F_LONGO;
                    end
                end
                F_LONGO: r_state <= F_LONWAIT;
                F_LONWAIT: begin
                    if (w_cd_done) begin
                        r_lon   <= w_angle;
                        r_state <= F_LATGO;
                    end
                end
                F_LATGO: r_state <= F_LATWAIT;
                F_LATWAIT: begin
                    if (w_cd_done) begin
                        r_lat   <= w_angle;
                        r_state <= F_MAP;
                    end
                end
                F_MAP: begin
                    r_job.kind     <= epz_pkg::JOB_POINT;
                    r_job.col      <= w_lon_v[31 -: epz_pkg::COL_BITS];
                    r_job.row      <= w_row_px;
                    r_job.distance <= r_dist[epz_pkg::RANGE_W-1:0];
                    r_state        <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign i_in.ready = (r_state == F_IDLE) && !i_hold;
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_job      = r_job;
endmodule

// ===== hw/rtl/epz_fifo.sv =====
// Short job queue between front and back ends.
// Depends on epz_pkg.
module epz_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  epz_pkg::t_job           i_job,
    input  logic                    i_pop,
    output epz_pkg::t_job           o_job,
    output epz_pkg::t_queue_status  o_status
);
    epz_pkg::t_job                  r_mem [epz_pkg::QUEUE_DEPTH];
    logic [epz_pkg::QUEUE_BITS-1:0] r_wp, r_rp;
    logic [epz_pkg::QUEUE_BITS:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_job           = r_mem[r_rp];
    assign o_status.empty  = (r_cnt == '0);
    assign o_status.full   = (r_cnt == (epz_pkg::QUEUE_BITS + 1)'(epz_pkg::QUEUE_DEPTH));
endmodule

// ===== hw/rtl/epz_back.sv =====
// Back end: clears the map after reset, then per job does the z-buffer
// read-modify-write, pixel read or direct reply. Needs epz_pkg, epz_if.
module epz_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  epz_pkg::t_job           i_job,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_clearing,
    epz_out_if.source               o_out
);
    localparam int WORD_W = 1 + epz_pkg::RANGE_W + epz_pkg::OWNER_W;

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_RMW} t_state;

    logic [WORD_W-1:0]                  mem [epz_pkg::MAP_CELLS];
    t_state                             r_state;
    logic [epz_pkg::CELL_BITS-1:0]      r_clr_addr;
    epz_pkg::t_job                      r_job;
    logic [WORD_W-1:0]                  r_rdata;
    epz_pkg::t_out_item                 r_out;
    logic                               r_out_valid;

    logic [epz_pkg::CELL_BITS-1:0]      w_addr, w_waddr;
    logic [WORD_W-1:0]                  w_wdata;
    logic                               w_we, w_filled, w_win;
    logic [epz_pkg::RANGE_W-1:0]        w_old_depth;
    logic [epz_pkg::OWNER_W-1:0]        w_old_owner, w_new_owner;

    assign w_addr      = {r_job.row, r_job.col};
    assign w_filled    = r_rdata[WORD_W-1];
    assign w_old_depth = r_rdata[WORD_W-2 -: epz_pkg::RANGE_W];
    assign w_old_owner = r_rdata[epz_pkg::OWNER_W-1:0];
    assign w_new_owner = epz_pkg::OWNER_W'(r_job.ordinal);
    assign w_win       = !w_filled || (r_job.distance < w_old_depth);
    assign w_we        = (r_state == B_CLEAR) ||
                         ((r_state == B_RMW) && (r_job.kind == epz_pkg::JOB_POINT) && w_win);
    assign w_waddr     = (r_state == B_CLEAR) ? r_clr_addr : w_addr;
    assign w_wdata     = (r_state == B_CLEAR) ? '0 : {1'b1, r_job.distance, w_new_owner};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_addr];
    end

    assign o_pop      = (r_state == B_IDLE) && !i_empty && !r_out_valid;
    assign o_clearing = (r_state == B_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_job <= i_job;
                        unique case (i_job.kind)
                            epz_pkg::JOB_READ: begin
                                if (i_job.in_map) begin
                                    r_state <= B_READ;
                                end else begin
                                    r_out <= '{
                                        pixel_column: epz_pkg::OUT_COL_W'(i_job.col),
                                        pixel_row:    epz_pkg::OUT_ROW_W'(i_job.row),
                                        default:      '0
                                    };
                                    r_out_valid <= 1'b1;
                                end
                            end
                            epz_pkg::JOB_POINT: r_state <= B_READ;
                            default: begin
                                r_out       <= '0;
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                B_READ: r_state <= B_RMW;
                B_RMW: begin
                    r_out.pixel_column <= epz_pkg::OUT_COL_W'(r_job.col);
                    r_out.pixel_row    <= epz_pkg::OUT_ROW_W'(r_job.row);
                    if (r_job.kind == epz_pkg::JOB_POINT) begin
                        r_out.accepted    <= 1'b1;
                        r_out.updated     <= w_win;
                        r_out.depth       <= w_win ? r_job.distance : w_old_depth;
                        r_out.owner_index <= w_win ? w_new_owner : w_old_owner;
                        r_out.owner_valid <= 1'b1;
                    end else begin
                        r_out.accepted    <= 1'b0;
                        r_out.updated     <= 1'b0;
                        r_out.depth       <= w_filled ? w_old_depth : '0;
                        r_out.owner_index <= w_filled ? w_old_owner : '0;
                        r_out.owner_valid <= w_filled;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// ===== hw/rtl/equirect_point_zbuffer_top.sv =====
// Top level of the equirectangular point z-buffer: configuration registers,
// front end, job queue and back end. Depends on epz_pkg, epz_if and all epz_* modules.
// Points go through 9 MACs, 3 squares, two 32-step square roots and two 30-step
// CORDIC runs; rejects end early. Front and back end each take one job at a time.
// Reset: synchronous; the map is then cleared cell by cell, input held off.
module equirect_point_zbuffer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    epz_in_if.sink                              i_in,
    epz_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [epz_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [epz_pkg::ROT_W-1:0]           i_cfg_data
);
    epz_pkg::t_cfg          r_cfg;
    epz_pkg::t_job          w_front_job, w_queue_job;
    epz_pkg::t_queue_status w_status;
    logic                   w_push, w_pop, w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot       <= '0;
            r_cfg.org_x     <= '0;
            r_cfg.org_y     <= '0;
            r_cfg.org_z     <= '0;
            r_cfg.min_range <= epz_pkg::MIN_RANGE_RST;
            r_cfg.max_range <= epz_pkg::MAX_RANGE_RST;
        end else if (i_cfg_we) begin
            unique case (epz_pkg::t_cfg_reg'(i_cfg_index))
                epz_pkg::CFG_ROT0:      r_cfg.rot[0]    <= i_cfg_data;
                epz_pkg::CFG_ROT1:      r_cfg.rot[1]    <= i_cfg_data;
                epz_pkg::CFG_ROT2:      r_cfg.rot[2]    <= i_cfg_data;
                epz_pkg::CFG_ORG_X:     r_cfg.org_x     <= $signed(i_cfg_data[31:0]);
                epz_pkg::CFG_ORG_Y:     r_cfg.org_y     <= $signed(i_cfg_data[31:0]);
                epz_pkg::CFG_ORG_Z:     r_cfg.org_z     <= $signed(i_cfg_data[31:0]);
                epz_pkg::CFG_MIN_RANGE: r_cfg.min_range <= i_cfg_data[30:0];
                epz_pkg::CFG_MAX_RANGE: r_cfg.max_range <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    epz_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hold  (w_clearing),
        .i_in    (i_in),
        .i_full  (w_status.full),
        .o_push  (w_push),
        .o_job   (w_front_job)
    );

    epz_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_queue_job),
        .o_status (w_status)
    );

    epz_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_queue_job),
        .i_empty    (w_status.empty),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_out      (o_out)
    );

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !i_in.ready)
        else $error("input accepted during map clear");

    a_updated_implies_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.updated) |-> o_out.data.accepted)
        else $error("update reported for a point that was not accepted");

    a_empty_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.owner_valid) |->
            (o_out.data.depth == '0 && o_out.data.owner_index == '0))
        else $error("empty pixel reports depth or owner");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_status.full)
        else $error("job pushed into full queue");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_status.empty)
        else $error("job popped from empty queue");
endmodule
